// ===== design/spscr_pkg.sv =====
// Package for the SPI slave command/readback block.
// Holds the item and result types, frame constants and the table geometry.
// No dependencies; the table, core and top-level files import it.
package spscr_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [7:0]  DEPTH_LAST  = 8'(TABLE_DEPTH);
    localparam logic [7:0]  TEST_ENTRY  = 8'd1;
    localparam logic [15:0] TEST_WORD   = 16'hF055;
    localparam logic [7:0]  TIMEOUT_RST = 8'd15;
    localparam logic [7:0]  IDLE_MAX    = 8'd255;

    localparam logic [4:0] CMD_BITS    = 5'd8;
    localparam logic [4:0] FRAME_BITS  = 5'd24;
    localparam logic [4:0] BIT_CNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        CMD_PIN    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TBL_WR = 2'd2,
        CMD_FETCH  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic        sck_level;
        logic        di_level;
        logic [7:0]  table_index;
        logic [15:0] table_value;
    } t_item;

    typedef struct packed {
        logic        miso_level;
        logic        frame_done;
        logic [7:0]  command_out;
        logic [15:0] data_out;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        logic [15:0]       data;
    } t_tbl_wr;

    // Entry numbers run from 1 to the table depth.
    function automatic logic entry_valid(input logic [7:0] num);
        return (num >= 8'd1) && (num <= DEPTH_LAST);
    endfunction

endpackage

// ===== design/spscr_ifs.sv =====
// Valid/ready channel interfaces for the SPI slave command/readback block.
// One interface for input items and one for result items; no dependencies.
interface spscr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        sck_level;
    logic        di_level;
    logic [7:0]  table_index;
    logic [15:0] table_value;

    modport source (output valid, cmd, sck_level, di_level, table_index, table_value,
                    input ready);
    modport sink (input valid, cmd, sck_level, di_level, table_index, table_value,
                  output ready);
endinterface

interface spscr_out_if;
    logic        valid;
    logic        ready;
    logic        miso_level;
    logic        frame_done;
    logic [7:0]  command_out;
    logic [15:0] data_out;

    modport source (output valid, miso_level, frame_done, command_out, data_out,
                    input ready);
    modport sink (input valid, miso_level, frame_done, command_out, data_out,
                  output ready);
endinterface

// ===== design/spscr_table.sv =====
// Readback table: a small register file with one write and one read port.
// Depends on spscr_pkg for the depth, address width and test word.
module spscr_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spscr_pkg::t_tbl_wr         i_wr,
    input  logic [spscr_pkg::TBL_AW-1:0] i_rd_addr,
    output logic [15:0]                o_rd_data
);
    import spscr_pkg::*;

    localparam logic [TBL_AW-1:0] TEST_SLOT = TBL_AW'(TEST_ENTRY - 8'd1);

    logic [15:0] r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_mem[k] <= (TBL_AW'(k) == TEST_SLOT) ? TEST_WORD : 16'h0000;
            end
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_mem[i_rd_addr];

endmodule

// ===== design/spscr_core.sv =====
// Frame state of the SPI slave: bit counter, shift registers, timeout and
// latched command. Updates once per stepped item. Depends on spscr_pkg and
// spscr_table.
module spscr_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_step,
    input  spscr_pkg::t_item     i_item,
    output spscr_pkg::t_result   o_res
);
    import spscr_pkg::*;

    logic        r_exp_lvl, n_exp_lvl;
    logic [4:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_cmd_sh, n_cmd_sh;
    logic [15:0] r_din_sh, n_din_sh;
    logic [15:0] r_dout_sh, n_dout_sh;
    logic [7:0]  r_idle, n_idle;
    logic        r_done, n_done;
    logic [7:0]  r_lcmd, n_lcmd;
    logic [15:0] r_ldat, n_ldat;
    logic        r_miso, n_miso;
    logic [7:0]  r_timeout;

    logic [7:0]        cmd_next;
    logic [4:0]        cnt_inc;
    logic [7:0]        idle_inc;
    logic [TBL_AW-1:0] rd_addr;
    logic [15:0]       rd_data;
    t_tbl_wr           tbl_wr;

    // The command byte as it stands after this rising edge; it selects the
    // readback word when it is complete.
    assign cmd_next = {r_cmd_sh[6:0], i_item.di_level};
    assign cnt_inc  = (r_bit_cnt < BIT_CNT_MAX) ? r_bit_cnt + 5'd1 : r_bit_cnt;
    assign idle_inc = (r_idle < IDLE_MAX) ? r_idle + 8'd1 : r_idle;
    assign rd_addr  = TBL_AW'(cmd_next - 8'd1);

    spscr_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_exp_lvl = r_exp_lvl;
        n_bit_cnt = r_bit_cnt;
        n_cmd_sh  = r_cmd_sh;
        n_din_sh  = r_din_sh;
        n_dout_sh = r_dout_sh;
        n_idle    = r_idle;
        n_done    = r_done;
        n_lcmd    = r_lcmd;
        n_ldat    = r_ldat;
        n_miso    = r_miso;
        tbl_wr    = '0;
        o_res     = '0;
        if (i_step) begin
            case (i_item.cmd)
                CMD_PIN: begin
                    n_idle = 8'd0;
                    if (i_item.sck_level == r_exp_lvl) begin
                        n_exp_lvl = ~r_exp_lvl;
                        if (i_item.sck_level) begin
                            n_bit_cnt = cnt_inc;
                            if (cnt_inc <= CMD_BITS) begin
                                n_cmd_sh = cmd_next;
                            end else if (cnt_inc <= FRAME_BITS) begin
                                n_din_sh = {r_din_sh[14:0], i_item.di_level};
                            end
                            if (cnt_inc == CMD_BITS && entry_valid(cmd_next)) begin
                                n_dout_sh = rd_data;
                            end
                        end else begin
                            if (r_bit_cnt >= CMD_BITS && r_bit_cnt < FRAME_BITS) begin
                                n_miso    = r_dout_sh[15];
                                n_dout_sh = {r_dout_sh[14:0], 1'b0};
                            end
                            if (r_bit_cnt >= FRAME_BITS) begin
                                n_bit_cnt = 5'd0;
                                n_lcmd    = r_cmd_sh;
                                n_ldat    = r_din_sh;
                                n_done    = 1'b1;
                                n_miso    = 1'b0;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_bit_cnt != 5'd0) begin
                        n_idle = idle_inc;
                        if (idle_inc >= r_timeout) begin
                            n_bit_cnt = 5'd0;
                        end
                    end
                    o_res.frame_done = r_done;
                    n_done = 1'b0;
                end
                CMD_TBL_WR: begin
                    if (entry_valid(i_item.table_index)) begin
                        tbl_wr.en   = 1'b1;
                        tbl_wr.addr = TBL_AW'(i_item.table_index - 8'd1);
                        tbl_wr.data = i_item.table_value;
                    end
                end
                CMD_FETCH: begin
                    o_res.command_out = r_lcmd;
                    o_res.data_out    = r_ldat;
                    n_lcmd = 8'd0;
                end
                default: begin
                end
            endcase
        end
        o_res.miso_level = n_miso;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_lvl <= 1'b1;
            r_bit_cnt <= 5'd0;
            r_cmd_sh  <= 8'd0;
            r_din_sh  <= 16'd0;
            r_dout_sh <= 16'd0;
            r_idle    <= 8'd0;
            r_done    <= 1'b0;
            r_lcmd    <= 8'd0;
            r_ldat    <= 16'd0;
            r_miso    <= 1'b0;
            r_timeout <= TIMEOUT_RST;
        end else begin
            r_exp_lvl <= n_exp_lvl;
            r_bit_cnt <= n_bit_cnt;
            r_cmd_sh  <= n_cmd_sh;
            r_din_sh  <= n_din_sh;
            r_dout_sh <= n_dout_sh;
            r_idle    <= n_idle;
            r_done    <= n_done;
            r_lcmd    <= n_lcmd;
            r_ldat    <= n_ldat;
            r_miso    <= n_miso;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // A falling edge always follows the 24th rising edge before another
    // rising edge, so the counter never runs past a full frame.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= FRAME_BITS)
        else $error("bit counter ran past the frame length");

    a_done_miso_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> !r_miso)
        else $error("MISO not released at frame end");

    a_lvl_pin_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && i_item.cmd == CMD_PIN) |=> $stable(r_exp_lvl))
        else $error("expected clock level moved without a pin event");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd == CMD_PIN) |=> (r_idle == 8'd0))
        else $error("idle tick count not cleared by a pin event");

endmodule

// ===== design/spi_slave_command_readback.sv =====
// SPI slave command/readback block, top level.
// Input items arrive on i_in (valid/ready) and each one gives exactly one
// result item on o_out. An item is a sampled clock-pin event, a poll tick,
// a readback table write or a fetch of the last latched command and data.
// Frames are 24 bits: an 8-bit command selects a readback word that later
// falling edges shift out on miso_level, while 16 data bits are shifted in.
// i_cfg_we/i_cfg_wdata write the idle timeout in poll ticks (reset 15).
// An accepted item is held in the input register, the core computes its
// result from there, and the result is loaded into the output register.
// Throughput: one item per cycle, as long as the result register is empty
// or taken in that cycle.
// When o_out stalls, the input register holds at most one further item and
// i_in.ready drops until the result is taken.
// Reset (synchronous, active low) clears the frame state, the channels and
// the readback table, whose entry 1 then holds the test word F055 hex.
// Depends on spscr_pkg, spscr_ifs and spscr_core.
module spi_slave_command_readback (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    spscr_in_if.sink          i_in,
    spscr_out_if.source       o_out
);
    import spscr_pkg::*;

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_res;
    logic    step;
    t_result core_res;

    assign step       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item <= '{cmd:         t_cmd'(i_in.cmd),
                        sck_level:   i_in.sck_level,
                        di_level:    i_in.di_level,
                        table_index: i_in.table_index,
                        table_value: i_in.table_value};
        end
        if (step) begin
            r_res <= core_res;
        end
    end

    spscr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (r_item),
        .o_res       (core_res)
    );

    assign o_out.valid       = r_out_vld;
    assign o_out.miso_level  = r_res.miso_level;
    assign o_out.frame_done  = r_res.frame_done;
    assign o_out.command_out = r_res.command_out;
    assign o_out.data_out    = r_res.data_out;

endmodule
